[hdl/cctok_pkg.sv]
// shared types, constants and character classes of the command tokenizer
`default_nettype none
package cctok_pkg;

  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam int unsigned PosW     = 12;
  localparam int unsigned CntW     = 5;
  localparam int unsigned IdxW     = 4;
  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [CntW-1:0] CntMax = CntW'(16);
  localparam logic [IdxW-1:0] IdxMax = '1;

  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChQuote = 8'h22;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_NAME,
    PH_PREOPEN,
    PH_ARGS,
    PH_PLAIN,
    PH_QUOTED
  } phase_e;

  typedef enum logic [2:0] {
    EV_NAME,
    EV_ARGCH,
    EV_ARGEND,
    EV_ACCEPT,
    EV_ERROR
  } event_e;

  typedef enum logic [1:0] {
    ERR_NAME,
    ERR_BLOCK_BEGIN,
    ERR_ARGUMENT,
    ERR_BLOCK_END
  } err_e;

  typedef struct packed {
    event_e          ev;
    logic [7:0]      ch;
    logic [IdxW-1:0] idx;
    err_e            err;
    logic [PosW-1:0] pos;
  } res_t;

  // one accepted item's results: always a first one, optionally a second
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } cmd_t;

  function automatic res_t mk_res(event_e ev, logic [7:0] ch, logic [IdxW-1:0] idx,
                                  err_e err, logic [PosW-1:0] pos);
    res_t r;
    r.ev  = ev;
    r.ch  = ch;
    r.idx = idx;
    r.err = err;
    r.pos = pos;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_name_char(logic [7:0] c);
    return is_letter(c) || (c inside {8'h5F, 8'h2E});
  endfunction

  function automatic logic is_arg_char(logic [7:0] c);
    return is_letter(c) || (c inside {[8'h30:8'h39], 8'h5F, 8'h2E, 8'h3B, 8'h2D});
  endfunction

  function automatic logic [IdxW-1:0] sat_idx(logic [CntW-1:0] cnt);
    return (cnt > CntW'(IdxMax)) ? IdxMax : cnt[IdxW-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/cctok_front.sv]
// front end: takes characters, tracks the parse state and forms result commands
`default_nettype none
module cctok_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      char_code_i,
  input  wire logic            end_marker_i,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output cctok_pkg::cmd_t      cmd_o
);

  cctok_pkg::phase_e                  phase_q, phase_d;
  logic [cctok_pkg::PosW-1:0]         pos_q, pos_d;
  logic [cctok_pkg::CntW-1:0]         cnt_q, cnt_d;
  logic                               fin_q, fin_d;

  logic                               accept;
  logic [cctok_pkg::CntW-1:0]         cnt_inc;
  logic [cctok_pkg::CntW-1:0]         cnt_sel;
  logic                               args_has;
  cctok_pkg::res_t                    args_res;
  cctok_pkg::phase_e                  args_phase;
  logic                               args_fin;
  logic                               n0, n1;
  cctok_pkg::res_t                    r0, r1;
  logic [7:0]                         c;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign c          = char_code_i;
  assign cnt_inc    = (cnt_q < cctok_pkg::CntMax) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_sel    = (phase_q == cctok_pkg::PH_PLAIN) ? cnt_inc : cnt_q;

  // argument block handling, shared by the plain argument end path
  always_comb begin
    args_has   = 1'b0;
    args_phase = cctok_pkg::PH_ARGS;
    args_fin   = 1'b0;
    args_res   = cctok_pkg::mk_res(cctok_pkg::EV_ERROR, 8'h00, '0,
                                   cctok_pkg::ERR_BLOCK_END, pos_q);
    if (c == cctok_pkg::ChClose) begin
      args_has = 1'b1;
      args_fin = 1'b1;
      args_res = cctok_pkg::mk_res(cctok_pkg::EV_ACCEPT, 8'h00, cctok_pkg::sat_idx(cnt_sel),
                                   cctok_pkg::ERR_NAME, pos_q);
    end else if (c == cctok_pkg::ChQuote) begin
      args_phase = cctok_pkg::PH_QUOTED;
    end else if (cctok_pkg::is_arg_char(c)) begin
      args_has   = 1'b1;
      args_phase = cctok_pkg::PH_PLAIN;
      args_res   = cctok_pkg::mk_res(cctok_pkg::EV_ARGCH, c, cctok_pkg::sat_idx(cnt_sel),
                                     cctok_pkg::ERR_NAME, pos_q);
    end else if (c == cctok_pkg::ChComma) begin
      if (cnt_sel == '0) begin
        args_has = 1'b1;
        args_fin = 1'b1;
        args_res = cctok_pkg::mk_res(cctok_pkg::EV_ERROR, 8'h00, '0,
                                     cctok_pkg::ERR_ARGUMENT, pos_q);
      end
    end else if (!cctok_pkg::is_space(c)) begin
      args_has = 1'b1;
      args_fin = 1'b1;
    end
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    pos_d   = (pos_q < cctok_pkg::PosMax) ? pos_q + 1'b1 : pos_q;
    n0      = 1'b0;
    n1      = 1'b0;
    r0      = cctok_pkg::mk_res(cctok_pkg::EV_ERROR, 8'h00, '0, cctok_pkg::ERR_NAME, pos_q);
    r1      = cctok_pkg::mk_res(cctok_pkg::EV_ERROR, 8'h00, '0,
                                cctok_pkg::ERR_BLOCK_END, pos_q);
    if (end_marker_i) begin
      if (!fin_q) begin
        n0 = 1'b1;
        case (phase_q)
          cctok_pkg::PH_PREOPEN: r0.err = cctok_pkg::ERR_BLOCK_BEGIN;
          cctok_pkg::PH_ARGS:    r0.err = cctok_pkg::ERR_BLOCK_END;
          cctok_pkg::PH_PLAIN, cctok_pkg::PH_QUOTED: begin
            r0 = cctok_pkg::mk_res(cctok_pkg::EV_ARGEND, 8'h00, cctok_pkg::sat_idx(cnt_q),
                                   cctok_pkg::ERR_NAME, pos_q);
            n1 = 1'b1;
          end
          default: r0.err = cctok_pkg::ERR_NAME;
        endcase
      end
      phase_d = cctok_pkg::PH_LEAD;
      pos_d   = '0;
      cnt_d   = '0;
      fin_d   = 1'b0;
    end else if (!fin_q) begin
      case (phase_q)
        cctok_pkg::PH_LEAD: begin
          if (cctok_pkg::is_name_char(c)) begin
            n0      = 1'b1;
            r0      = cctok_pkg::mk_res(cctok_pkg::EV_NAME, c, '0, cctok_pkg::ERR_NAME, pos_q);
            phase_d = cctok_pkg::PH_NAME;
          end else if (!cctok_pkg::is_space(c)) begin
            n0    = 1'b1;
            fin_d = 1'b1;
          end
        end
        cctok_pkg::PH_NAME, cctok_pkg::PH_PREOPEN: begin
          if (phase_q == cctok_pkg::PH_NAME && cctok_pkg::is_name_char(c)) begin
            n0 = 1'b1;
            r0 = cctok_pkg::mk_res(cctok_pkg::EV_NAME, c, '0, cctok_pkg::ERR_NAME, pos_q);
          end else if (c == cctok_pkg::ChOpen) begin
            phase_d = cctok_pkg::PH_ARGS;
          end else begin
            phase_d = cctok_pkg::PH_PREOPEN;
            if (!cctok_pkg::is_space(c)) begin
              n0     = 1'b1;
              r0.err = cctok_pkg::ERR_BLOCK_BEGIN;
              fin_d  = 1'b1;
            end
          end
        end
        cctok_pkg::PH_QUOTED: begin
          n0 = 1'b1;
          if (c == cctok_pkg::ChQuote) begin
            r0      = cctok_pkg::mk_res(cctok_pkg::EV_ARGEND, 8'h00, cctok_pkg::sat_idx(cnt_q),
                                        cctok_pkg::ERR_NAME, pos_q);
            cnt_d   = cnt_inc;
            phase_d = cctok_pkg::PH_ARGS;
          end else begin
            r0 = cctok_pkg::mk_res(cctok_pkg::EV_ARGCH, c, cctok_pkg::sat_idx(cnt_q),
                                   cctok_pkg::ERR_NAME, pos_q);
          end
        end
        cctok_pkg::PH_PLAIN: begin
          n0 = 1'b1;
          if (cctok_pkg::is_arg_char(c)) begin
            r0 = cctok_pkg::mk_res(cctok_pkg::EV_ARGCH, c, cctok_pkg::sat_idx(cnt_q),
                                   cctok_pkg::ERR_NAME, pos_q);
          end else begin
            r0      = cctok_pkg::mk_res(cctok_pkg::EV_ARGEND, 8'h00, cctok_pkg::sat_idx(cnt_q),
                                        cctok_pkg::ERR_NAME, pos_q);
            cnt_d   = cnt_inc;
            n1      = args_has;
            r1      = args_res;
            phase_d = args_phase;
            fin_d   = args_fin;
          end
        end
        default: begin
          n0      = args_has;
          r0      = args_res;
          phase_d = args_phase;
          fin_d   = args_fin;
        end
      endcase
    end
  end

  assign push_o    = accept && n0;
  assign cmd_o.two = n1;
  assign cmd_o.r0  = r0;
  assign cmd_o.r1  = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cctok_pkg::PH_LEAD;
      pos_q   <= '0;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
    end
  end

endmodule
`default_nettype wire

[hdl/cctok_queue.sv]
// short command queue between the front end and the back end
`default_nettype none
module cctok_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire cctok_pkg::cmd_t push_cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output cctok_pkg::cmd_t      head_o
);

  cctok_pkg::cmd_t                 mem_q [cctok_pkg::QDepth];
  logic [cctok_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [cctok_pkg::QCntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == cctok_pkg::QCntW'(cctok_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/cctok_back.sv]
// back end: sends the one or two results of each queued command
`default_nettype none
module cctok_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire cctok_pkg::cmd_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output cctok_pkg::res_t      out_res_o,
  output logic                 out_last_o
);

  logic sub_q;
  logic xfer;

  assign out_valid_o = !empty_i;
  assign out_res_o   = sub_q ? head_i.r1 : head_i.r0;
  assign out_last_o  = sub_q || !head_i.two;
  assign xfer        = out_valid_o && out_ready_i;
  assign pop_o       = xfer && out_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else if (xfer) begin
      sub_q <= !out_last_o;
    end
  end

endmodule
`default_nettype wire

[hdl/console_command_tokenizer_unit.sv]
// top level of the console command tokenizer
// each input transfer's results are registered in the queue, whose head drives the output
// throughput: one character per cycle unless the queue is full; two results are sent in turn
// a four-entry command queue absorbs output stalls, input stalls only when it is full
// reset: asynchronous, active low; parser returns to the leading-space phase, queue empties
`default_nettype none
module console_command_tokenizer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tuser,   // [0] end_marker
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] out_char, [11:8] arg_index,
                                           // [13:12] error_kind, [25:14] position, zero above
  output logic [2:0]       m_axis_tuser,   // [2:0] event_res
  output logic             m_axis_tlast    // last_of_run
);

  logic              push, full, pop, empty;
  cctok_pkg::cmd_t   push_cmd, head;
  cctok_pkg::res_t   res;

  cctok_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .char_code_i  (s_axis_tdata),
    .end_marker_i (s_axis_tuser),
    .q_full_i     (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  cctok_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  cctok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = res.ev;
  assign m_axis_tdata = {6'b0, res.pos, res.err, res.idx, res.ch};

endmodule
`default_nettype wire
